// File: design/ttsf_pkg.sv
package ttsf_pkg;

   // field and format widths
   localparam int unsigned COORD_W   = 32;
   localparam int unsigned CSR_W     = 16;
   localparam int unsigned EDGE_W    = 33;
   localparam int unsigned REJ_W     = 40;
   localparam int unsigned PROD_W    = 65;
   localparam int unsigned SUM_W     = 67;
   localparam int unsigned DOT_W     = 38;
   localparam int unsigned FRAC_Q30  = 30;
   localparam int unsigned ROOT_STEPS = 32;
   localparam int unsigned QUOT_BITS  = 31;
   localparam int unsigned SPLIT_LO   = 18;

   // reset threshold and its square
   localparam logic [CSR_W-1:0]    MIN_LEN_RST = 16'd1;
   localparam logic [2*CSR_W-1:0]  MIN_SQ_RST  = 32'd1;
   localparam logic [CSR_W:0]      SHORT_LIMIT = 17'd65536;

   localparam logic signed [SUM_W-1:0]   HALF_Q30 = 67'sd536870912;
   localparam logic signed [COORD_W-1:0] Q30_ONE  = 32'sh4000_0000;
   localparam logic signed [COORD_W-1:0] Q30_MONE = -32'sh4000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_x;
      logic signed [COORD_W-1:0] a_y;
      logic signed [COORD_W-1:0] a_z;
      logic signed [COORD_W-1:0] b_x;
      logic signed [COORD_W-1:0] b_y;
      logic signed [COORD_W-1:0] b_z;
      logic signed [COORD_W-1:0] c_x;
      logic signed [COORD_W-1:0] c_y;
      logic signed [COORD_W-1:0] c_z;
   } req_type;

   typedef struct packed {
      logic                      valid_res;
      logic                      origin_coord;
      logic signed [COORD_W-1:0] b_along_u;
      logic signed [COORD_W-1:0] b_along_v;
      logic signed [COORD_W-1:0] c_along_u;
      logic signed [COORD_W-1:0] c_along_v;
      logic signed [COORD_W-1:0] axis_u_x;
      logic signed [COORD_W-1:0] axis_u_y;
      logic signed [COORD_W-1:0] axis_u_z;
      logic signed [COORD_W-1:0] axis_v_x;
      logic signed [COORD_W-1:0] axis_v_y;
      logic signed [COORD_W-1:0] axis_v_z;
   } rsp_type;

   // round a q30 product sum to q16.16, nearest with halves up
   function automatic logic signed [DOT_W-1:0] rnd_q30(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] t;
      t = s + HALF_Q30;
      return DOT_W'(t >>> FRAC_Q30);
   endfunction

   // clamp to the 32-bit signed range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [DOT_W-1:0] x);
      logic signed [DOT_W-1:0] hi;
      logic signed [DOT_W-1:0] lo;
      hi = DOT_W'(32'sh7fff_ffff);
      lo = DOT_W'(32'sh8000_0000);
      if (x > hi) return 32'sh7fff_ffff;
      if (x < lo) return 32'sh8000_0000;
      return COORD_W'(x);
   endfunction

endpackage

// File: design/ttsf_norm.sv
module ttsf_norm
   import ttsf_pkg::*;
#(
   parameter int unsigned W  = EDGE_W,
   parameter int unsigned SW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [2:0][W-1:0]     in_vec,
   input  logic [SW-1:0]         in_side,
   output logic                  out_vld,
   output logic [2:0][COORD_W-1:0] out_vec,
   output logic [SW-1:0]         out_side
);

   localparam int unsigned PW = $clog2(W);

   typedef struct packed {
      logic [63:0]         x;
      logic [63:0]         r;
      logic [2:0][31:0]    mag;
      logic [2:0]          neg;
      logic                zero;
      logic [SW-1:0]       side;
   } root_type;

   typedef struct packed {
      logic [2:0][63:0]          rem;
      logic [2:0][QUOT_BITS-1:0] quo;
      logic [31:0]               len;
      logic [2:0]                neg;
      logic                      zero;
      logic [SW-1:0]             side;
   } quot_type;

   // one digit of the square root
   function automatic root_type root_step(input root_type s, input int k);
      logic [64:0] trial;
      logic [63:0] b;
      root_type    o;
      o     = s;
      b     = 64'(1) << (62 - 2 * k);
      trial = {1'b0, s.r} + {1'b0, b};
      if ({1'b0, s.x} >= trial) begin
         o.x = s.x - trial[63:0];
         o.r = (s.r >> 1) + b;
      end else begin
         o.r = s.r >> 1;
      end
      return o;
   endfunction

   // one quotient bit for all three lanes
   function automatic quot_type quot_step(input quot_type s, input int bitpos);
      logic [63:0] dv;
      quot_type    o;
      o  = s;
      dv = 64'(s.len) << bitpos;
      for (int i = 0; i < 3; i++) begin
         if (s.rem[i] >= dv) begin
            o.rem[i]         = s.rem[i] - dv;
            o.quo[i][bitpos] = 1'b1;
         end
      end
      return o;
   endfunction

   logic [2:0][W-1:0]  mag1_ff, mag1_in, mag2_ff;
   logic [2:0]         neg1_ff, neg1_in, neg2_ff, neg4_ff, neg4_in, neg5_ff;
   logic [SW-1:0]      side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;
   logic               vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   logic [PW-1:0]      pos2_ff, pos2_in;
   logic               zero2_ff, zero2_in, zero3_ff, zero4_ff, zero5_ff;
   logic [2:0][32:0]   t3_ff, t3_in;
   logic [2:0][31:0]   mag4_ff, mag4_in, mag5_ff;
   logic [2:0][63:0]   sq5_ff;
   root_type           rt_ff [ROOT_STEPS+1];
   logic [ROOT_STEPS:0] rv_ff;
   quot_type           dv_ff [QUOT_BITS+1];
   quot_type           dv_in;
   logic [QUOT_BITS:0] qv_ff;
   logic [2:0][COORD_W-1:0] out_ff, out_in;
   logic [SW-1:0]      oside_ff;
   logic               ovld_ff;

   // magnitudes and signs
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][W-1];
         mag1_in[i] = in_vec[i][W-1] ? W'(-in_vec[i]) : in_vec[i];
      end
   end

   // leading one of the largest magnitude
   always_comb begin
      logic [W-1:0] orv;
      orv     = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      pos2_in = '0;
      for (int k = 0; k < W; k++) begin
         if (orv[k]) pos2_in = PW'(k);
      end
      zero2_in = (orv == '0);
   end

   // scale so the largest magnitude sits in [2^30, 2^31)
   always_comb begin
      logic signed [W:0]    tw;
      logic signed [W+30:0] tx;
      for (int i = 0; i < 3; i++) begin
         tw = neg2_ff[i] ? -$signed({1'b0, mag2_ff[i]}) : $signed({1'b0, mag2_ff[i]});
         tx = (W+31)'(tw);
         if (int'(pos2_ff) < FRAC_Q30) tx = tx <<< (FRAC_Q30 - int'(pos2_ff));
         else tx = tx >>> (int'(pos2_ff) - FRAC_Q30);
         t3_in[i] = tx[32:0];
      end
   end

   // magnitudes of the scaled vector
   always_comb begin
      logic [32:0] tn;
      for (int i = 0; i < 3; i++) begin
         tn         = -t3_ff[i];
         neg4_in[i] = t3_ff[i][32];
         mag4_in[i] = t3_ff[i][32] ? tn[31:0] : t3_ff[i][31:0];
      end
   end

   // quotient setup: numerator is mag * 2^30 plus half the length
   always_comb begin
      dv_in      = '0;
      dv_in.len  = rt_ff[ROOT_STEPS].r[31:0];
      dv_in.neg  = rt_ff[ROOT_STEPS].neg;
      dv_in.zero = rt_ff[ROOT_STEPS].zero;
      dv_in.side = rt_ff[ROOT_STEPS].side;
      for (int i = 0; i < 3; i++) begin
         dv_in.rem[i] = (64'(rt_ff[ROOT_STEPS].mag[i]) << FRAC_Q30)
                        + 64'(rt_ff[ROOT_STEPS].r[31:1]);
      end
   end

   // signed unit components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_ff[QUOT_BITS].zero) out_in[i] = '0;
         else if (dv_ff[QUOT_BITS].neg[i]) out_in[i] = -{1'b0, dv_ff[QUOT_BITS].quo[i]};
         else out_in[i] = {1'b0, dv_ff[QUOT_BITS].quo[i]};
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         side1_ff <= in_side;
         pos2_ff  <= pos2_in;
         zero2_ff <= zero2_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         side2_ff <= side1_ff;
         t3_ff    <= t3_in;
         zero3_ff <= zero2_ff;
         side3_ff <= side2_ff;
         mag4_ff  <= mag4_in;
         neg4_ff  <= neg4_in;
         zero4_ff <= zero3_ff;
         side4_ff <= side3_ff;
         for (int i = 0; i < 3; i++) sq5_ff[i] <= 64'(mag4_ff[i]) * 64'(mag4_ff[i]);
         mag5_ff  <= mag4_ff;
         neg5_ff  <= neg4_ff;
         zero5_ff <= zero4_ff;
         side5_ff <= side4_ff;
         rt_ff[0].x    <= sq5_ff[0] + sq5_ff[1] + sq5_ff[2];
         rt_ff[0].r    <= '0;
         rt_ff[0].mag  <= mag5_ff;
         rt_ff[0].neg  <= neg5_ff;
         rt_ff[0].zero <= zero5_ff;
         rt_ff[0].side <= side5_ff;
         for (int k = 0; k < ROOT_STEPS; k++) rt_ff[k+1] <= root_step(rt_ff[k], k);
         dv_ff[0] <= dv_in;
         for (int j = 0; j < QUOT_BITS; j++) begin
            dv_ff[j+1] <= quot_step(dv_ff[j], QUOT_BITS - 1 - j);
         end
         out_ff   <= out_in;
         oside_ff <= dv_ff[QUOT_BITS].side;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         rv_ff   <= '0;
         qv_ff   <= '0;
         ovld_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         rv_ff   <= {rv_ff[ROOT_STEPS-1:0], vld5_ff};
         qv_ff   <= {qv_ff[QUOT_BITS-1:0], rv_ff[ROOT_STEPS]};
         ovld_ff <= qv_ff[QUOT_BITS];
      end
   end

   assign out_vld  = ovld_ff;
   assign out_vec  = out_ff;
   assign out_side = oside_ff;

endmodule

// File: design/triangle_tangent_space_flatten.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_data (req_type, three vertices)
// rsp     | out       | rsp_valid / rsp_ready | rsp_data (rsp_type, frame and coords)
// csr     | in        | csr_wr_en             | csr_wr_data (min_length)
//
// one triangle per cycle while rsp is not stalled
// the two normalize units step through 32 root digits and 31 quotient bits each
// synchronous active-high reset clears valid bits and sets min_length to 1
// a stalled rsp freezes the whole pipeline; req_ready stays high while rsp is empty or taken
module triangle_tangent_space_flatten
   import ttsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   typedef struct packed {
      logic [2:0][EDGE_W-1:0] e1;
      logic [2:0][EDGE_W-1:0] e2;
      logic                   bad;
   } n1_side_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] u;
      logic [2:0][EDGE_W-1:0]  e1;
      logic [2:0][EDGE_W-1:0]  e2;
      logic [DOT_W-1:0]        d;
      logic [DOT_W-1:0]        bu;
      logic                    bad;
   } n2_side_type;

   logic en;
   logic [2*CSR_W-1:0] ml_sq_ff;

   // stage registers
   logic                    v1_ff, v2_ff, v3_ff;
   logic [2:0][EDGE_W-1:0]  e1_1_ff, e2_1_ff, e1_2_ff, e2_2_ff;
   logic [2:0][EDGE_W-1:0]  e1_1_in, e2_1_in;
   logic [2:0][2*CSR_W-1:0] sq2_ff, sq2_in;
   logic                    sm2_ff, sm2_in;
   n1_side_type             s3_ff, s3_in;

   logic                    n1_vld;
   logic [2:0][COORD_W-1:0] n1_u;
   n1_side_type             n1_side;

   logic                    v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic [2:0][PROD_W-1:0]  pd4_ff, pb4_ff, pd4_in, pb4_in;
   n1_side_type             s4_ff;
   logic [2:0][COORD_W-1:0] u4_ff;
   n2_side_type             s5_ff, s5_in, s6_ff, s7_ff, s8_ff, s9_ff, s10_ff, s10_in;
   logic [2:0][50:0]        pl6_ff, pl6_in;
   logic [2:0][51:0]        ph6_ff, ph6_in;
   logic [2:0][DOT_W-1:0]   r7_ff, r7_in;
   logic [2:0][REJ_W-1:0]   w8_ff, w8_in, w9_ff;
   logic [2:0][2*CSR_W-1:0] sq9_ff, sq9_in;
   logic                    sm9_ff, sm9_in;

   logic                    n2_vld;
   logic [2:0][COORD_W-1:0] n2_v;
   n2_side_type             n2_side;

   logic                    v11_ff, v12_ff;
   logic [2:0][PROD_W-1:0]  pv1_11_ff, pv2_11_ff, pv1_11_in, pv2_11_in;
   logic [2:0][COORD_W-1:0] v11v_ff, v12v_ff;
   n2_side_type             s11_ff, s12_ff;
   logic [DOT_W-1:0]        bv12_ff, cv12_ff, bv12_in, cv12_in;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // threshold register holds min_length squared
   always_ff @(posedge clock) begin
      if (reset) begin
         ml_sq_ff <= MIN_SQ_RST;
      end else if (csr_wr_en) begin
         ml_sq_ff <= (2*CSR_W)'(csr_wr_data) * (2*CSR_W)'(csr_wr_data);
      end
   end

   // edge vectors
   always_comb begin
      e1_1_in[0] = EDGE_W'(req_data.b_x) - EDGE_W'(req_data.a_x);
      e1_1_in[1] = EDGE_W'(req_data.b_y) - EDGE_W'(req_data.a_y);
      e1_1_in[2] = EDGE_W'(req_data.b_z) - EDGE_W'(req_data.a_z);
      e2_1_in[0] = EDGE_W'(req_data.c_x) - EDGE_W'(req_data.a_x);
      e2_1_in[1] = EDGE_W'(req_data.c_y) - EDGE_W'(req_data.a_y);
      e2_1_in[2] = EDGE_W'(req_data.c_z) - EDGE_W'(req_data.a_z);
   end

   // short edge test, squares of small components
   always_comb begin
      logic [EDGE_W-1:0] ab;
      sm2_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         ab        = e1_1_ff[i][EDGE_W-1] ? -e1_1_ff[i] : e1_1_ff[i];
         sm2_in    = sm2_in && (ab < EDGE_W'(SHORT_LIMIT));
         sq2_in[i] = (2*CSR_W)'(ab[CSR_W-1:0]) * (2*CSR_W)'(ab[CSR_W-1:0]);
      end
   end

   // short edge test, compare
   always_comb begin
      logic [2*CSR_W+1:0] sum;
      sum       = (2*CSR_W+2)'(sq2_ff[0]) + (2*CSR_W+2)'(sq2_ff[1])
                  + (2*CSR_W+2)'(sq2_ff[2]);
      s3_in.e1  = e1_2_ff;
      s3_in.e2  = e2_2_ff;
      s3_in.bad = sm2_ff && (sum < (2*CSR_W+2)'(ml_sq_ff));
   end

   // front stages
   always_ff @(posedge clock) begin
      if (en) begin
         e1_1_ff <= e1_1_in;
         e2_1_ff <= e2_1_in;
         e1_2_ff <= e1_1_ff;
         e2_2_ff <= e2_1_ff;
         sq2_ff  <= sq2_in;
         sm2_ff  <= sm2_in;
         s3_ff   <= s3_in;
      end
   end

   // first axis
   ttsf_norm #(
      .W  (EDGE_W),
      .SW ($bits(n1_side_type))
   ) u_norm_u (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (v3_ff),
      .in_vec   (s3_ff.e1),
      .in_side  (s3_ff),
      .out_vld  (n1_vld),
      .out_vec  (n1_u),
      .out_side (n1_side)
   );

   // dot products of u with both edges
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd4_in[i] = PROD_W'($signed(n1_u[i])) * PROD_W'($signed(n1_side.e2[i]));
         pb4_in[i] = PROD_W'($signed(n1_u[i])) * PROD_W'($signed(n1_side.e1[i]));
      end
   end

   // sums rounded to q16.16
   always_comb begin
      s5_in.u   = u4_ff;
      s5_in.e1  = s4_ff.e1;
      s5_in.e2  = s4_ff.e2;
      s5_in.bad = s4_ff.bad;
      s5_in.d   = rnd_q30(SUM_W'($signed(pd4_ff[0])) + SUM_W'($signed(pd4_ff[1]))
                          + SUM_W'($signed(pd4_ff[2])));
      s5_in.bu  = rnd_q30(SUM_W'($signed(pb4_ff[0])) + SUM_W'($signed(pb4_ff[1]))
                          + SUM_W'($signed(pb4_ff[2])));
   end

   // u times d as two partial products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pl6_in[i] = 51'($signed(s5_ff.u[i])) * 51'($signed({1'b0, s5_ff.d[SPLIT_LO-1:0]}));
         ph6_in[i] = 52'($signed(s5_ff.u[i])) * 52'($signed(s5_ff.d[DOT_W-1:SPLIT_LO]));
      end
   end

   // projection term rounded to q16.16
   always_comb begin
      logic signed [71:0] prod;
      for (int i = 0; i < 3; i++) begin
         prod     = (72'($signed(ph6_ff[i])) <<< SPLIT_LO) + 72'($signed(pl6_ff[i]));
         r7_in[i] = rnd_q30(SUM_W'(prod));
      end
   end

   // remove the projection
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w8_in[i] = REJ_W'($signed(s7_ff.e2[i])) - REJ_W'($signed(r7_ff[i]));
      end
   end

   // short rejected edge, squares
   always_comb begin
      logic [REJ_W-1:0] ab;
      sm9_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         ab        = w8_ff[i][REJ_W-1] ? -w8_ff[i] : w8_ff[i];
         sm9_in    = sm9_in && (ab < REJ_W'(SHORT_LIMIT));
         sq9_in[i] = (2*CSR_W)'(ab[CSR_W-1:0]) * (2*CSR_W)'(ab[CSR_W-1:0]);
      end
   end

   // short rejected edge, compare
   always_comb begin
      logic [2*CSR_W+1:0] sum;
      sum        = (2*CSR_W+2)'(sq9_ff[0]) + (2*CSR_W+2)'(sq9_ff[1])
                   + (2*CSR_W+2)'(sq9_ff[2]);
      s10_in     = s9_ff;
      s10_in.bad = s9_ff.bad || (sm9_ff && (sum < (2*CSR_W+2)'(ml_sq_ff)));
   end

   // middle stages
   always_ff @(posedge clock) begin
      if (en) begin
         pd4_ff  <= pd4_in;
         pb4_ff  <= pb4_in;
         s4_ff   <= n1_side;
         u4_ff   <= n1_u;
         s5_ff   <= s5_in;
         pl6_ff  <= pl6_in;
         ph6_ff  <= ph6_in;
         s6_ff   <= s5_ff;
         r7_ff   <= r7_in;
         s7_ff   <= s6_ff;
         w8_ff   <= w8_in;
         s8_ff   <= s7_ff;
         sq9_ff  <= sq9_in;
         sm9_ff  <= sm9_in;
         w9_ff   <= w8_ff;
         s9_ff   <= s8_ff;
         s10_ff  <= s10_in;
      end
   end

   logic [2:0][REJ_W-1:0] w10_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         w10_ff <= w9_ff;
      end
   end

   // second axis
   ttsf_norm #(
      .W  (REJ_W),
      .SW ($bits(n2_side_type))
   ) u_norm_v (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (v10_ff),
      .in_vec   (w10_ff),
      .in_side  (s10_ff),
      .out_vld  (n2_vld),
      .out_vec  (n2_v),
      .out_side (n2_side)
   );

   // dot products of v with both edges
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv1_11_in[i] = PROD_W'($signed(n2_v[i])) * PROD_W'($signed(n2_side.e1[i]));
         pv2_11_in[i] = PROD_W'($signed(n2_v[i])) * PROD_W'($signed(n2_side.e2[i]));
      end
   end

   always_comb begin
      bv12_in = rnd_q30(SUM_W'($signed(pv1_11_ff[0])) + SUM_W'($signed(pv1_11_ff[1]))
                        + SUM_W'($signed(pv1_11_ff[2])));
      cv12_in = rnd_q30(SUM_W'($signed(pv2_11_ff[0])) + SUM_W'($signed(pv2_11_ff[1]))
                        + SUM_W'($signed(pv2_11_ff[2])));
   end

   // result beat, zero for degenerate triangles
   always_comb begin
      rsp_in = '0;
      if (!s12_ff.bad) begin
         rsp_in.valid_res = 1'b1;
         rsp_in.b_along_u = sat32($signed(s12_ff.bu));
         rsp_in.b_along_v = sat32($signed(bv12_ff));
         rsp_in.c_along_u = sat32($signed(s12_ff.d));
         rsp_in.c_along_v = sat32($signed(cv12_ff));
         rsp_in.axis_u_x  = s12_ff.u[0];
         rsp_in.axis_u_y  = s12_ff.u[1];
         rsp_in.axis_u_z  = s12_ff.u[2];
         rsp_in.axis_v_x  = v12v_ff[0];
         rsp_in.axis_v_y  = v12v_ff[1];
         rsp_in.axis_v_z  = v12v_ff[2];
      end
   end

   // back stages
   always_ff @(posedge clock) begin
      if (en) begin
         pv1_11_ff <= pv1_11_in;
         pv2_11_ff <= pv2_11_in;
         v11v_ff   <= n2_v;
         s11_ff    <= n2_side;
         bv12_ff   <= bv12_in;
         cv12_ff   <= cv12_in;
         v12v_ff   <= v11v_ff;
         s12_ff    <= s11_ff;
         rsp_ff    <= rsp_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         v12_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= n1_vld;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         v10_ff       <= v9_ff;
         v11_ff       <= n2_vld;
         v12_ff       <= v11_ff;
         rsp_valid_ff <= v12_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // degenerate triangles report all zeros
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data == '0)
      else $error("degenerate beat carries nonzero fields");

   // x components of both axes stay within one in q2.30
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.valid_res |->
         rsp_data.axis_u_x <= Q30_ONE && rsp_data.axis_u_x >= Q30_MONE &&
         rsp_data.axis_v_x <= Q30_ONE && rsp_data.axis_v_x >= Q30_MONE)
      else $error("axis component out of range");

   // a stall freezes every top-level valid bit of the pipeline
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff,
                       v9_ff, v10_ff, v11_ff, v12_ff, rsp_valid_ff}))
      else $error("pipeline moved during a stall");

   // a pending result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output blocked");

endmodule
